// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the pattern match unit.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define SPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every rising edge, reset included.
`define SPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SPM_ASSERT(lbl, prop, msg)
`define SPM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/spm_pkg.sv -----
// Types and constants of the stream pattern match unit.
// No dependencies.
package spm_pkg;

  localparam int PAT_BYTES = 32;
  localparam int PAT_WORDS = 4;
  localparam int LEN_W     = 6;
  localparam int CNT_W     = 6;
  localparam int POS_W     = 32;
  localparam int APB_AW    = 6;
  localparam int APB_DW    = 64;

  typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

  typedef enum logic [2:0] {
    REG_LEN  = 3'd0,
    REG_PAT0 = 3'd1,
    REG_PAT1 = 3'd2,
    REG_PAT2 = 3'd3,
    REG_PAT3 = 3'd4
  } reg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [LEN_W-1:0] len;
    pattern_t         pattern;
  } cfg_t;

endpackage

// ----- hdl/spm_if.sv -----
// Stream interfaces of the pattern match unit: text bytes in, results out.
// Depends on spm_pkg.
interface spm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface spm_result_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [spm_pkg::POS_W-1:0]      start_pos;
  logic [spm_pkg::POS_W-1:0]      end_pos;
  logic [spm_pkg::CNT_W-1:0]      match_number;
  logic                           stopped;

  modport source (output valid, output found, output start_pos, output end_pos,
                  output match_number, output stopped, input ready);
  modport sink (input valid, input found, input start_pos, input end_pos,
                input match_number, input stopped, output ready);
endinterface

// ----- hdl/spm_cell.sv -----
// One window cell: holds one text byte, passes it on at each shift and
// compares the incoming byte with its pattern byte. Depends on spm_pkg.
module spm_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        shift_en,
  input  logic [7:0]                  byte_in,
  input  logic [spm_pkg::LEN_W-1:0]   len,
  input  spm_pkg::pattern_t           pattern,
  output logic [7:0]                  byte_out,
  output logic                        eq
);

  logic [7:0]                byte_r;
  logic [spm_pkg::LEN_W-1:0] pidx;
  logic                      active;

  // cell IDX compares its incoming byte with pattern byte len-1-IDX
  assign active = spm_pkg::LEN_W'(IDX) < len;
  assign pidx   = len - spm_pkg::LEN_W'(1) - spm_pkg::LEN_W'(IDX);
  assign eq     = !active || (byte_in == pattern[pidx[4:0]]);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

endmodule

// ----- hdl/spm_cell_row.sv -----
// Row of window cells forming the shift line and its per-byte compares.
// Depends on spm_pkg and spm_cell.
module spm_cell_row #(
  parameter int WINDOW_MAX = 32
) (
  input  logic          clk,
  input  logic          shift_en,
  input  logic [7:0]    text_byte,
  input  spm_pkg::cfg_t cfg,
  output logic          all_eq
);

  logic [WINDOW_MAX-1:0][7:0] byte_q;
  logic [WINDOW_MAX-1:0]      eq;

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    logic [7:0] byte_in;
    if (k == 0) begin : g_head
      assign byte_in = text_byte;
    end else begin : g_link
      assign byte_in = byte_q[k-1];
    end
    spm_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .byte_in  (byte_in),
      .len      (cfg.len),
      .pattern  (cfg.pattern),
      .byte_out (byte_q[k]),
      .eq       (eq[k])
    );
  end

  assign all_eq = &eq;

endmodule

// ----- hdl/spm_cfg_regs.sv -----
// APB register file: pattern length and the four pattern words.
// Depends on spm_pkg.
module spm_cfg_regs #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spm_pkg::APB_AW-1:0]   paddr,
  input  logic [spm_pkg::APB_DW-1:0]   pwdata,
  output logic [spm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output spm_pkg::cfg_t                cfg
);

  localparam int LenMax = (WINDOW_MAX < spm_pkg::PAT_BYTES) ? WINDOW_MAX : spm_pkg::PAT_BYTES;

  logic [spm_pkg::LEN_W-1:0]                         len_r;
  logic [spm_pkg::PAT_WORDS-1:0][spm_pkg::APB_DW-1:0] word_r;
  spm_pkg::reg_idx_t                                 idx;
  logic                                              wr;

  assign pready = 1'b1;
  assign idx    = spm_pkg::reg_idx_t'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= spm_pkg::LEN_W'(1);
      word_r <= '0;
    end else if (wr) begin
      case (idx)
        spm_pkg::REG_LEN:  len_r     <= pwdata[spm_pkg::LEN_W-1:0];
        spm_pkg::REG_PAT0: word_r[0] <= pwdata;
        spm_pkg::REG_PAT1: word_r[1] <= pwdata;
        spm_pkg::REG_PAT2: word_r[2] <= pwdata;
        spm_pkg::REG_PAT3: word_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      spm_pkg::REG_LEN:  prdata = {{(spm_pkg::APB_DW-spm_pkg::LEN_W){1'b0}}, len_r};
      spm_pkg::REG_PAT0: prdata = word_r[0];
      spm_pkg::REG_PAT1: prdata = word_r[1];
      spm_pkg::REG_PAT2: prdata = word_r[2];
      spm_pkg::REG_PAT3: prdata = word_r[3];
      default:           prdata = '0;
    endcase
  end

  // zero length counts as one; clamp to the window
  always_comb begin
    if (len_r == '0) begin
      cfg.len = spm_pkg::LEN_W'(1);
    end else if (len_r > spm_pkg::LEN_W'(LenMax)) begin
      cfg.len = spm_pkg::LEN_W'(LenMax);
    end else begin
      cfg.len = len_r;
    end
    for (int b = 0; b < spm_pkg::PAT_BYTES; b++) begin
      cfg.pattern[b] = word_r[b / 8][(b % 8)*8 +: 8];
    end
  end

endmodule

// ----- hdl/stream_pattern_match_unit.sv -----
// Streaming pattern match unit. One text byte per item, one result per item.
// An item is taken in every cycle in which the output register is empty or its
// result is being taken; its result appears in the output register in the next
// cycle, so the sustained rate is one item per clock while results are taken.
// The rate is set by the combinational compare of the incoming byte and the
// window against the pattern across the whole cell row. No clearing pass after
// reset. Write configuration only while idle. After MATCH_LIMIT matches the unit
// reports stopped for every further item and keeps its state.
module stream_pattern_match_unit #(
  parameter int WINDOW_MAX  = 32,
  parameter int MATCH_LIMIT = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  spm_byte_if.sink                    in_if,
  spm_result_if.source                out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spm_pkg::APB_AW-1:0]  paddr,
  input  logic [spm_pkg::APB_DW-1:0]  pwdata,
  output logic [spm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  `include "assert_macros.svh"

  spm_pkg::cfg_t cfg;

  logic                         in_ready;
  logic                         acc;
  logic                         shift_en;
  logic                         all_eq;
  logic                         match;
  logic [spm_pkg::POS_W-1:0]    pos_inc;
  logic [spm_pkg::CNT_W-1:0]    cnt_inc;

  logic [spm_pkg::POS_W-1:0]    position_r, position_nxt;
  logic [spm_pkg::CNT_W-1:0]    match_count_r, match_count_nxt;
  logic                         halted_r, halted_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic                         found_r, found_nxt;
  logic [spm_pkg::POS_W-1:0]    start_r, start_nxt;
  logic [spm_pkg::POS_W-1:0]    end_r, end_nxt;
  logic [spm_pkg::CNT_W-1:0]    num_r, num_nxt;
  logic                         stopped_r, stopped_nxt;

  spm_cfg_regs #(.WINDOW_MAX(WINDOW_MAX)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spm_cell_row #(.WINDOW_MAX(WINDOW_MAX)) u_row (
    .clk       (clk),
    .shift_en  (shift_en),
    .text_byte (in_if.text_byte),
    .cfg       (cfg),
    .all_eq    (all_eq)
  );

  // take a new item while the output register is empty or the held result leaves
  assign in_ready    = !out_valid_r || out_if.ready;
  assign in_if.ready = in_ready;
  assign acc         = in_if.valid && in_ready;
  assign shift_en    = acc && !halted_r;

  assign pos_inc = (position_r == '1) ? position_r : position_r + spm_pkg::POS_W'(1);
  assign cnt_inc = match_count_r + spm_pkg::CNT_W'(1);
  assign match   = (pos_inc >= {{(spm_pkg::POS_W-spm_pkg::LEN_W){1'b0}}, cfg.len}) && all_eq;

  always_comb begin
    position_nxt    = position_r;
    match_count_nxt = match_count_r;
    halted_nxt      = halted_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    found_nxt       = found_r;
    start_nxt       = start_r;
    end_nxt         = end_r;
    num_nxt         = num_r;
    stopped_nxt     = stopped_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
      if (halted_r) begin
        found_nxt   = 1'b0;
        start_nxt   = '0;
        end_nxt     = '0;
        num_nxt     = '0;
        stopped_nxt = 1'b1;
      end else begin
        position_nxt = pos_inc;
        end_nxt      = pos_inc;
        found_nxt    = match;
        if (match) begin
          match_count_nxt = cnt_inc;
          halted_nxt      = cnt_inc >= spm_pkg::CNT_W'(MATCH_LIMIT);
          start_nxt       = pos_inc - {{(spm_pkg::POS_W-spm_pkg::LEN_W){1'b0}}, cfg.len}
                            + spm_pkg::POS_W'(1);
          num_nxt         = cnt_inc;
          stopped_nxt     = cnt_inc >= spm_pkg::CNT_W'(MATCH_LIMIT);
        end else begin
          start_nxt   = '0;
          num_nxt     = '0;
          stopped_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r    <= '0;
      match_count_r <= '0;
      halted_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      position_r    <= position_nxt;
      match_count_r <= match_count_nxt;
      halted_r      <= halted_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r   <= found_nxt;
    start_r   <= start_nxt;
    end_r     <= end_nxt;
    num_r     <= num_nxt;
    stopped_r <= stopped_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.found        = found_r;
  assign out_if.start_pos    = start_r;
  assign out_if.end_pos      = end_r;
  assign out_if.match_number = num_r;
  assign out_if.stopped      = stopped_r;

  `SPM_ASSERT(a_halt_sticks, halted_r |=> halted_r, "halt cleared without reset")
  `SPM_ASSERT(a_halted_result, (acc && halted_r) |=> (out_valid_r && stopped_r && !found_r), "item after halt not reported as stopped")
  `SPM_ASSERT(a_count_bound, match_count_r <= spm_pkg::CNT_W'(MATCH_LIMIT), "match count passed limit")
  `SPM_ASSERT(a_found_fields, (out_valid_r && found_r) |-> (num_r != '0 && start_r <= end_r), "match result fields inconsistent")
  `SPM_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_r |-> in_ready, "input stalled with empty output register")

endmodule

// ----- bench/tb_stream_pattern_match_unit.sv -----
`timescale 1ns / 1ps
// Regression bench for stream_pattern_match_unit: feeds text bytes, programs the pattern
// registers over APB, predicts every match report and checks it field by field.
// Depends on spm_pkg, the spm stream interfaces and the unit itself.
module tb_stream_pattern_match_unit;

  localparam int WINDOW_MAX          = 32;
  localparam int MATCH_LIMIT         = 32;
  localparam int CLK_HALF_NS         = 4;
  localparam int RESET_CYCLES        = 10;
  localparam int DRAIN_CYCLES        = 4;
  localparam int HOLDOFF_CYCLES      = 60;
  localparam int NUM_REGS            = 5;
  localparam int REG_STRIDE          = 8;
  localparam int RANDOM_MATCH_BUDGET = 24;
  localparam int SEGMENT_ITEMS       = 115;
  localparam int SEGMENTS_PER_PHASE  = 3;
  localparam int PLANTS_PER_SEGMENT  = 2;
  localparam int TIMEOUT_NS          = 4000000;
  localparam logic [spm_pkg::POS_W-1:0] POS_MAX = '1;

  typedef struct {
    logic                      found;
    logic [spm_pkg::POS_W-1:0] start_pos;
    logic [spm_pkg::POS_W-1:0] end_pos;
    logic [spm_pkg::CNT_W-1:0] match_number;
    logic                      stopped;
  } scan_report_t;

  typedef enum {
    SEG_OVER_MAX, SEG_ALL_ONES, SEG_JUST_OVER, SEG_ALL_ZERO, SEG_TWO_SYMBOL,
    SEG_ANY_LEN, SEG_SHORT
  } seg_style_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [spm_pkg::APB_AW-1:0] paddr;
  logic [spm_pkg::APB_DW-1:0] pwdata;
  logic [spm_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  spm_byte_if   byte_ch ();
  spm_result_if report_ch ();

  stream_pattern_match_unit #(
    .WINDOW_MAX  (WINDOW_MAX),
    .MATCH_LIMIT (MATCH_LIMIT)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (byte_ch),
    .out_if  (report_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the pattern registers and of the search state
  logic [spm_pkg::LEN_W-1:0]  len_reg;
  logic [spm_pkg::APB_DW-1:0] pat_words [spm_pkg::PAT_WORDS];
  logic [7:0]                 window_q [WINDOW_MAX];
  logic [spm_pkg::POS_W-1:0]  pos_q;
  logic [spm_pkg::CNT_W-1:0]  match_count_q;
  logic                       halted_q;

  scan_report_t scan_reports_due [$];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_holding   = 1'b0;
  event        start_holdoff;
  int unsigned seg_no          = 0;
  int unsigned bytes_sent      = 0;
  int unsigned reports_checked = 0;
  int unsigned matches_checked = 0;
  int unsigned stops_checked   = 0;
  int unsigned reg_writes      = 0;
  int unsigned mismatch_count  = 0;

  always #(CLK_HALF_NS) clk = ~clk;

  function automatic int unsigned active_len();
    int unsigned n;
    n = 32'(len_reg);
    if (n < 1) n = 1;
    if (n > WINDOW_MAX) n = WINDOW_MAX;
    if (n > spm_pkg::PAT_BYTES) n = spm_pkg::PAT_BYTES;
    return n;
  endfunction

  function automatic logic [7:0] pattern_byte(int unsigned i);
    return pat_words[i / 8][8 * (i % 8) +: 8];
  endfunction

  // Shift one byte into the window and work out the report it causes.
  function automatic scan_report_t scan_text_byte(logic [7:0] b);
    scan_report_t r;
    int unsigned  n;
    logic         hit;
    r = '{found: 1'b0, start_pos: '0, end_pos: '0, match_number: '0, stopped: 1'b0};
    if (halted_q) begin
      r.stopped = 1'b1;
      return r;
    end
    for (int i = WINDOW_MAX - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = b;
    if (pos_q != POS_MAX) pos_q = pos_q + 1'b1;
    n = active_len();
    hit = (pos_q >= n);
    for (int i = 0; i < n; i++) begin
      if (pattern_byte(i) != window_q[n-1-i]) hit = 1'b0;
    end
    r.end_pos = pos_q;
    if (hit) begin
      match_count_q = match_count_q + 1'b1;
      if (match_count_q >= MATCH_LIMIT) halted_q = 1'b1;
      r.found        = 1'b1;
      r.start_pos    = pos_q - n + 32'd1;
      r.match_number = match_count_q;
      r.stopped      = halted_q;
    end
    return r;
  endfunction

  // Once the random match budget is spent, never let a byte complete the pattern.
  function automatic logic [7:0] hold_back_match(logic [7:0] b);
    if (match_count_q >= RANDOM_MATCH_BUDGET && b == pattern_byte(active_len() - 1))
      return b ^ 8'h01;
    return b;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.text_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    scan_reports_due.push_back(scan_text_byte(b));
    bytes_sent++;
  endtask

  task automatic send_pattern();
    for (int i = 0; i < active_len(); i++) send_byte(pattern_byte(i));
  endtask

  // Drop valid and hold until every report has come back.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (scan_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_addr(input logic [spm_pkg::APB_AW-1:0] addr,
                            input logic [spm_pkg::APB_DW-1:0] data);
    wait_drained();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr / REG_STRIDE == spm_pkg::REG_LEN)
      len_reg = data[spm_pkg::LEN_W-1:0];
    else if (addr / REG_STRIDE >= spm_pkg::REG_PAT0 && addr / REG_STRIDE <= spm_pkg::REG_PAT3)
      pat_words[addr / REG_STRIDE - spm_pkg::REG_PAT0] = data;
    reg_writes++;
  endtask

  task automatic write_reg(input spm_pkg::reg_idx_t idx,
                           input logic [spm_pkg::APB_DW-1:0] data);
    write_addr(spm_pkg::APB_AW'(idx * REG_STRIDE), data);
  endtask

  task automatic load_segment_pattern();
    logic [spm_pkg::LEN_W-1:0]  len;
    logic [spm_pkg::APB_DW-1:0] words [spm_pkg::PAT_WORDS];
    logic [7:0]                 sym [2];
    seg_style_t                 style;
    style  = (seg_no <= SEG_TWO_SYMBOL) ? seg_style_t'(seg_no)
                                        : seg_style_t'($urandom_range(SEG_ANY_LEN, SEG_SHORT));
    sym[0] = 8'($urandom);
    sym[1] = 8'($urandom);
    len    = spm_pkg::LEN_W'($urandom_range(1, spm_pkg::PAT_BYTES));
    for (int w = 0; w < spm_pkg::PAT_WORDS; w++) words[w] = {$urandom, $urandom};
    case (style)
      SEG_OVER_MAX: len = '1;
      SEG_ALL_ONES: begin
        len = spm_pkg::LEN_W'(spm_pkg::PAT_BYTES);
        for (int w = 0; w < spm_pkg::PAT_WORDS; w++) words[w] = '1;
      end
      SEG_JUST_OVER: len = spm_pkg::LEN_W'(spm_pkg::PAT_BYTES + 1);
      SEG_ALL_ZERO: begin
        for (int w = 0; w < spm_pkg::PAT_WORDS; w++) words[w] = '0;
      end
      SEG_TWO_SYMBOL: begin
        // two symbols only, so prefixes overlap and partial compares get deep
        len = spm_pkg::LEN_W'($urandom_range(4, spm_pkg::PAT_BYTES));
        for (int i = 0; i < spm_pkg::PAT_BYTES; i++)
          words[i / 8][8 * (i % 8) +: 8] = sym[$urandom_range(0, 1)];
      end
      SEG_ANY_LEN: len = spm_pkg::LEN_W'($urandom_range(0, (1 << spm_pkg::LEN_W) - 1));
      default: len = spm_pkg::LEN_W'($urandom_range(1, 8));
    endcase
    write_reg(spm_pkg::REG_LEN, spm_pkg::APB_DW'(len));
    for (int w = 0; w < spm_pkg::PAT_WORDS; w++)
      write_reg(spm_pkg::reg_idx_t'(spm_pkg::REG_PAT0 + w), words[w]);
    seg_no++;
  endtask

  task automatic run_segment();
    int unsigned sent;
    int unsigned plants;
    int unsigned n;
    int unsigned k;
    int unsigned flip;
    logic [7:0]  b;
    load_segment_pattern();
    sent   = 0;
    plants = 0;
    n      = active_len();
    while (sent < SEGMENT_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_byte(hold_back_match(8'($urandom_range(0, 255))));
          sent++;
        end
        9: begin
          if (plants < PLANTS_PER_SEGMENT && match_count_q < RANDOM_MATCH_BUDGET) begin
            send_pattern();
            plants++;
            sent += n;
          end else begin
            send_byte(hold_back_match(8'($urandom_range(0, 255))));
            sent++;
          end
        end
        default: begin
          // pattern prefix; a whole one gets one byte spoilt
          k    = $urandom_range(1, n);
          flip = (k == n) ? $urandom_range(0, n - 1) : n;
          for (int i = 0; i < k; i++) begin
            b = pattern_byte(i);
            if (i == flip) b = b ^ 8'($urandom_range(1, 255));
            send_byte(hold_back_match(b));
            sent++;
          end
        end
      endcase
    end
  endtask

  // Zeros against the reset pattern: the window matches in content but must wait until it is full.
  task automatic test_window_filling();
    write_reg(spm_pkg::REG_LEN, spm_pkg::APB_DW'(5));
    repeat (5) send_byte(8'h00);
    write_reg(spm_pkg::REG_LEN, spm_pkg::APB_DW'(1));
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_zero_length();
    write_reg(spm_pkg::REG_LEN, spm_pkg::APB_DW'(0));
    write_reg(spm_pkg::REG_PAT0, {$urandom, 24'($urandom), 8'hA5});
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'hFF);
  endtask

  // A match whose first bytes arrive before the length grows.
  task automatic test_length_change();
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    a = 8'($urandom);
    b = 8'($urandom);
    c = 8'($urandom);
    write_reg(spm_pkg::REG_LEN, spm_pkg::APB_DW'(2));
    write_reg(spm_pkg::REG_PAT0, {$urandom, 16'($urandom), b, a});
    send_byte(a);
    send_byte(b);
    write_reg(spm_pkg::REG_LEN, spm_pkg::APB_DW'(3));
    write_reg(spm_pkg::REG_PAT0, {$urandom, 8'($urandom), c, b, a});
    send_byte(c);
  endtask

  task automatic test_unmapped_registers();
    for (int i = NUM_REGS; i < (1 << spm_pkg::APB_AW) / REG_STRIDE; i++)
      write_addr(spm_pkg::APB_AW'(i * REG_STRIDE), {$urandom, $urandom});
    send_pattern();
  endtask

  task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (SEGMENTS_PER_PHASE) run_segment();
  endtask

  task automatic test_receiver_holdoff();
    tx_idle_pct  = 0;
    rx_stall_pct = 6;
    -> start_holdoff;
    repeat (24) send_byte(hold_back_match(8'($urandom_range(0, 255))));
  endtask

  task automatic test_match_limit();
    tx_idle_pct  = 6;
    rx_stall_pct = 6;
    write_reg(spm_pkg::REG_LEN, spm_pkg::APB_DW'(4));
    write_reg(spm_pkg::REG_PAT0, {$urandom, $urandom});
    while (!halted_q) send_pattern();
    // halted: a fresh pattern changes nothing
    write_reg(spm_pkg::REG_LEN, spm_pkg::APB_DW'(1));
    write_reg(spm_pkg::REG_PAT0, '0);
    rx_stall_pct = 76;
    repeat (40) send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin
    if (rx_holding) report_ch.ready <= 1'b0;
    else report_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always begin
    @(start_holdoff);
    rx_holding <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    rx_holding <= 1'b0;
  end

  always @(posedge clk) begin
    scan_report_t want;
    if (rst_n && report_ch.valid && report_ch.ready) begin
      if (scan_reports_due.size() == 0) begin
        $error("report with no byte outstanding: found %0b end_pos %0d",
               report_ch.found, report_ch.end_pos);
        mismatch_count++;
      end else begin
        want = scan_reports_due.pop_front();
        check_field("found", 64'(want.found), 64'(report_ch.found));
        check_field("start_pos", 64'(want.start_pos), 64'(report_ch.start_pos));
        check_field("end_pos", 64'(want.end_pos), 64'(report_ch.end_pos));
        check_field("match_number", 64'(want.match_number), 64'(report_ch.match_number));
        check_field("stopped", 64'(want.stopped), 64'(report_ch.stopped));
        reports_checked++;
        if (want.found) matches_checked++;
        if (want.stopped) stops_checked++;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.text_byte = '0;
    report_ch.ready   = 1'b0;
    len_reg           = spm_pkg::LEN_W'(1);
    for (int w = 0; w < spm_pkg::PAT_WORDS; w++) pat_words[w] = '0;
    for (int i = 0; i < WINDOW_MAX; i++) window_q[i] = '0;
    pos_q             = '0;
    match_count_q     = '0;
    halted_q          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_window_filling();
    test_zero_length();
    test_length_change();
    test_unmapped_registers();
    run_random_phase(0, 0);
    run_random_phase(76, 0);
    run_random_phase(0, 76);
    run_random_phase(6, 6);
    test_receiver_holdoff();
    test_match_limit();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d text bytes over %0d pattern setups and %0d register writes",
             bytes_sent, seg_no, reg_writes);
    $display("checked %0d reports: %0d matches, %0d after the match limit",
             reports_checked, matches_checked, stops_checked);
    if (mismatch_count == 0) begin
      $display("stream_pattern_match_unit regression: pass");
    end else begin
      $display("stream_pattern_match_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("stream_pattern_match_unit regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/spm_pkg.sv
hdl/spm_if.sv
hdl/spm_cell.sv
hdl/spm_cell_row.sv
hdl/spm_cfg_regs.sv
hdl/stream_pattern_match_unit.sv
bench/tb_stream_pattern_match_unit.sv
